// ===== hw/rtl/sbcr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbcr_pkg
// Shared types and constants for the sphere/box collision resolver.
// ----------------------------------------------------------------------------
package sbcr_pkg;

    localparam int DEF_MAX_BOXES = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int VAL_W = 32;
    localparam int RAD_W = 31;

    // configuration register indexes
    localparam logic [1:0] CFG_BOX_COUNT  = 2'd0;
    localparam logic [1:0] CFG_WALL_THR   = 2'd1;
    localparam logic [1:0] CFG_MAX_PASSES = 2'd2;

    localparam logic [6:0]  RST_BOX_COUNT  = 7'd0;
    localparam logic [16:0] RST_WALL_THR   = 17'd46334;
    localparam logic [3:0]  RST_MAX_PASSES = 4'd3;

    // input item op codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RSQ_MUL,
        S_RSQ_SET,
        S_BOX_START,
        S_BOX_RD,
        S_CLAMP,
        S_SQ_MUL,
        S_SQ_ACC,
        S_TEST,
        S_SQRT,
        S_PEN,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_END,
        S_PUSH_MUL,
        S_PUSH_ACC,
        S_DOT_MUL,
        S_DOT_ACC,
        S_CLASSIFY,
        S_VEL_CHK,
        S_VEL_MUL,
        S_VEL_ACC,
        S_NEXT,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_WRITE,
        DP_LOAD,
        DP_MUL_RSQ,
        DP_SET_RSQ,
        DP_CLAMP,
        DP_MUL_SQ,
        DP_ACC_SQ,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_PEN,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_END,
        DP_MUL_PUSH,
        DP_ACC_PUSH,
        DP_MUL_DOT,
        DP_ACC_DOT,
        DP_CLASSIFY,
        DP_MUL_VEL,
        DP_ACC_VEL,
        DP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic dsq_lt_rsq;
        logic dsq_zero;
        logic vel_adj;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/sbcr_ram.sv =====
// ----------------------------------------------------------------------------
// sbcr_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sbcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbcr_ctrl
// Sequencer: walks passes, boxes and the per-hit arithmetic steps.
// ----------------------------------------------------------------------------
module sbcr_ctrl import sbcr_pkg::*; #(
    parameter int MAX_BOXES = DEF_MAX_BOXES,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int CW    = $clog2(MAX_BOXES + 1),
    localparam int NUM_W = 32 + FRAC_BITS,
    localparam int SW    = $clog2(NUM_W)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_op,
    output logic          o_in_stall,
    input  logic [6:0]    i_box_count,
    input  logic [3:0]    i_max_passes,
    input  t_dp_status    i_status,
    output t_dp_cmd       o_cmd,
    output logic [CW-1:0] o_box_idx
);

    t_state        r_state, n_state;
    logic [1:0]    r_axis, n_axis;
    logic [SW-1:0] r_step, n_step;
    logic [CW-1:0] r_box, n_box;
    logic [3:0]    r_pass, n_pass;
    logic          r_any, n_any;
    logic [CW-1:0] c_count;

    assign c_count = (32'(i_box_count) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(i_box_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AX_X;
            r_step  <= '0;
            r_box   <= '0;
            r_pass  <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_step  <= n_step;
            r_box   <= n_box;
            r_pass  <= n_pass;
            r_any   <= n_any;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_step     = r_step;
        n_box      = r_box;
        n_pass     = r_pass;
        n_any      = r_any;
        o_cmd.op   = DP_NOP;
        o_cmd.axis = r_axis;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_op == OP_WRITE) begin
                        o_cmd.op = DP_WRITE;
                    end else begin
                        o_cmd.op = DP_LOAD;
                        n_state  = S_RSQ_MUL;
                    end
                end
            end
            S_RSQ_MUL: begin
                o_cmd.op = DP_MUL_RSQ;
                n_state  = S_RSQ_SET;
            end
            S_RSQ_SET: begin
                o_cmd.op = DP_SET_RSQ;
                n_pass   = '0;
                n_box    = '0;
                n_any    = 1'b0;
                n_state  = (i_max_passes == 4'd0) ? S_DONE : S_BOX_START;
            end
            S_BOX_START: begin
                if (r_box == c_count) begin
                    if (!r_any || (5'(r_pass) + 5'd1 == 5'(i_max_passes))) begin
                        n_state = S_DONE;
                    end else begin
                        n_pass = r_pass + 4'd1;
                        n_box  = '0;
                        n_any  = 1'b0;
                    end
                end else begin
                    n_state = S_BOX_RD;
                end
            end
            S_BOX_RD: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = DP_CLAMP;
                n_axis   = AX_X;
                n_state  = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                o_cmd.op = DP_MUL_SQ;
                n_state  = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                o_cmd.op = DP_ACC_SQ;
                if (r_axis == AX_Z) begin
                    n_state = S_TEST;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_TEST: begin
                if (i_status.dsq_lt_rsq) begin
                    o_cmd.op = DP_SQRT_INIT;
                    n_step   = '0;
                    n_state  = S_SQRT;
                end else begin
                    n_box   = r_box + 1'b1;
                    n_state = S_BOX_START;
                end
            end
            S_SQRT: begin
                o_cmd.op = DP_SQRT_STEP;
                if (r_step == SW'(31)) begin
                    n_state = S_PEN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_PEN: begin
                o_cmd.op = DP_PEN;
                n_axis   = AX_X;
                n_state  = i_status.dsq_zero ? S_PUSH_MUL : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.op = DP_DIV_INIT;
                n_step   = '0;
                n_state  = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.op = DP_DIV_STEP;
                if (r_step == SW'(NUM_W - 1)) begin
                    n_state = S_DIV_END;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DIV_END: begin
                o_cmd.op = DP_DIV_END;
                if (r_axis == AX_Z) begin
                    n_axis  = AX_X;
                    n_state = S_PUSH_MUL;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_PUSH_MUL: begin
                o_cmd.op = DP_MUL_PUSH;
                n_state  = S_PUSH_ACC;
            end
            S_PUSH_ACC: begin
                o_cmd.op = DP_ACC_PUSH;
                if (r_axis == AX_Z) begin
                    n_axis  = AX_X;
                    n_state = S_DOT_MUL;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_PUSH_MUL;
                end
            end
            S_DOT_MUL: begin
                o_cmd.op = DP_MUL_DOT;
                n_state  = S_DOT_ACC;
            end
            S_DOT_ACC: begin
                o_cmd.op = DP_ACC_DOT;
                if (r_axis == AX_Z) begin
                    n_state = S_CLASSIFY;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DOT_MUL;
                end
            end
            S_CLASSIFY: begin
                o_cmd.op = DP_CLASSIFY;
                n_axis   = AX_X;
                n_state  = S_VEL_CHK;
            end
            S_VEL_CHK: begin
                n_state = i_status.vel_adj ? S_VEL_MUL : S_NEXT;
            end
            S_VEL_MUL: begin
                o_cmd.op = DP_MUL_VEL;
                n_state  = S_VEL_ACC;
            end
            S_VEL_ACC: begin
                o_cmd.op = DP_ACC_VEL;
                if (r_axis == AX_Z) begin
                    n_state = S_NEXT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_VEL_MUL;
                end
            end
            S_NEXT: begin
                n_any   = 1'b1;
                n_box   = r_box + 1'b1;
                n_state = S_BOX_START;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = DP_OUT_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_box_idx = r_box;

endmodule

// ===== hw/rtl/sbcr_dp.sv =====
// ----------------------------------------------------------------------------
// sbcr_dp
// Datapath: box table, shared multiplier, bit-serial sqrt and divider,
// working position/velocity and the result register.
// ----------------------------------------------------------------------------
module sbcr_dp import sbcr_pkg::*; #(
    parameter int MAX_BOXES = DEF_MAX_BOXES,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int CW     = $clog2(MAX_BOXES + 1),
    localparam int AW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    localparam int NUM_W  = 32 + FRAC_BITS,
    localparam int NORM_W = FRAC_BITS + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [CW-1:0]           i_box_idx,
    input  logic [5:0]              i_box_slot,
    input  logic signed [VAL_W-1:0] i_value_a_x,
    input  logic signed [VAL_W-1:0] i_value_a_y,
    input  logic signed [VAL_W-1:0] i_value_a_z,
    input  logic signed [VAL_W-1:0] i_value_b_x,
    input  logic signed [VAL_W-1:0] i_value_b_y,
    input  logic signed [VAL_W-1:0] i_value_b_z,
    input  logic [RAD_W-1:0]        i_sphere_radius,
    input  logic [16:0]             i_wall_thr,
    input  logic                    i_out_stall,
    output t_dp_status              o_status,
    output logic                    o_out_valid,
    output logic                    o_hit,
    output logic                    o_last_was_wall,
    output logic                    o_floor_contact,
    output logic [5:0]              o_floor_box,
    output logic signed [VAL_W-1:0] o_out_pos_x,
    output logic signed [VAL_W-1:0] o_out_pos_y,
    output logic signed [VAL_W-1:0] o_out_pos_z,
    output logic signed [VAL_W-1:0] o_out_vel_x,
    output logic signed [VAL_W-1:0] o_out_vel_y,
    output logic signed [VAL_W-1:0] o_out_vel_z,
    output logic [RAD_W-1:0]        o_last_penetration,
    output logic [16:0]             o_floor_normal_y
);

    localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S32_MIN = -34'sd2147483648;
    localparam logic signed [NORM_W-1:0] ONE_FX = NORM_W'(1) <<< FRAC_BITS;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // shift right by FRAC_BITS, truncating toward zero, saturated to 32 bits
    function automatic logic signed [31:0] shr_trunc(input logic signed [67:0] p);
        logic [67:0]        m;
        logic signed [31:0] res;
        m = p[67] ? 68'(-p) : 68'(p);
        m = m >> FRAC_BITS;
        if (!p[67]) begin
            res = (m > 68'd2147483647) ? 32'sh7FFFFFFF : m[31:0];
        end else begin
            res = (m > 68'd2147483648) ? 32'sh80000000 : (~m[31:0] + 32'd1);
        end
        return res;
    endfunction

    // ---- box table: lo/hi bounds per axis -----------------------------------
    logic signed [31:0] c_wr_lo [3];
    logic signed [31:0] c_wr_hi [3];
    logic signed [31:0] c_in_a  [3];
    logic signed [31:0] c_in_b  [3];
    logic [191:0]       c_wdata;
    logic [191:0]       c_rdata;
    logic [31:0]        c_slot32;
    logic [31:0]        c_ridx32;
    logic               c_we;

    assign c_in_a[0] = i_value_a_x;
    assign c_in_a[1] = i_value_a_y;
    assign c_in_a[2] = i_value_a_z;
    assign c_in_b[0] = i_value_b_x;
    assign c_in_b[1] = i_value_b_y;
    assign c_in_b[2] = i_value_b_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_wr_lo[i] = sat32(34'(c_in_a[i]) - 34'(c_in_b[i]));
            c_wr_hi[i] = sat32(34'(c_in_a[i]) + 34'(c_in_b[i]));
            c_wdata[64*i +: 32]      = c_wr_lo[i];
            c_wdata[64*i + 32 +: 32] = c_wr_hi[i];
        end
    end

    assign c_slot32 = {26'd0, i_box_slot};
    assign c_ridx32 = 32'(i_box_idx);
    assign c_we     = (i_cmd.op == DP_WRITE) && (c_slot32 < 32'(MAX_BOXES));

    sbcr_ram #(
        .WIDTH (192),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_slot32[AW-1:0]),
        .i_wdata (c_wdata),
        .i_raddr (c_ridx32[AW-1:0]),
        .o_rdata (c_rdata)
    );

    // ---- working state ---------------------------------------------------------
    logic signed [31:0]       r_pos [3];
    logic signed [31:0]       r_vel [3];
    logic signed [31:0]       r_d   [3];
    logic signed [NORM_W-1:0] r_n   [3];
    logic [RAD_W-1:0]         r_rad;
    logic [63:0]              r_rsq;
    logic [63:0]              r_dsq;
    logic signed [65:0]       r_prod;
    logic [63:0]              r_sq_x, r_sq_res, r_sq_bit;
    logic [RAD_W-1:0]         r_pen;
    logic [NUM_W-1:0]         r_num, r_quo;
    logic [31:0]              r_rem;
    logic signed [67:0]       r_dot;
    logic signed [31:0]       r_dotv;
    logic                     r_wall, r_vadj, r_hit, r_floor;
    logic [CW-1:0]            r_fbox;
    logic [RAD_W-1:0]         r_pen_last;
    logic signed [NORM_W-1:0] r_fny;
    logic                     r_out_valid;

    logic signed [32:0] c_mul_a, c_mul_b;
    logic signed [31:0] c_shr;
    logic signed [31:0] c_clamp_d [3];
    logic [64:0]        c_sq_sum;
    logic [32:0]        c_div_trial;
    logic [32:0]        c_div_diff;
    logic [31:0]        c_d_mag;
    logic [NUM_W-1:0]   c_q;
    logic signed [31:0] c_dotv;
    logic [31:0]        c_ay;
    logic               c_wall;
    logic [1:0]         ax;

    assign ax    = i_cmd.axis;
    assign c_shr = shr_trunc({{2{r_prod[65]}}, r_prod});

    // operand selection for the shared multiplier
    always_comb begin
        c_mul_a = '0;
        c_mul_b = '0;
        case (i_cmd.op)
            DP_MUL_RSQ: begin
                c_mul_a = {2'b00, r_rad};
                c_mul_b = {2'b00, r_rad};
            end
            DP_MUL_SQ: begin
                c_mul_a = 33'(r_d[ax]);
                c_mul_b = 33'(r_d[ax]);
            end
            DP_MUL_PUSH: begin
                c_mul_a = 33'(r_n[ax]);
                c_mul_b = {2'b00, r_pen};
            end
            DP_MUL_DOT: begin
                c_mul_a = 33'(r_vel[ax]);
                c_mul_b = 33'(r_n[ax]);
            end
            DP_MUL_VEL: begin
                c_mul_a = 33'(r_n[ax]);
                c_mul_b = 33'(r_dotv);
            end
            default: begin
                c_mul_a = '0;
                c_mul_b = '0;
            end
        endcase
    end

    // clamp the sphere centre into the box and take the offset
    always_comb begin
        logic signed [31:0] lo, hi, c;
        for (int i = 0; i < 3; i++) begin
            lo = c_rdata[64*i +: 32];
            hi = c_rdata[64*i + 32 +: 32];
            c  = (r_pos[i] < hi) ? r_pos[i] : hi;
            if (lo > c) begin
                c = lo;
            end
            c_clamp_d[i] = sat32(34'(r_pos[i]) - 34'(c));
        end
    end

    assign c_sq_sum    = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign c_div_trial = {r_rem, r_num[NUM_W-1]};
    assign c_div_diff  = c_div_trial - {1'b0, r_sq_res[31:0]};
    assign c_d_mag     = r_d[ax][31] ? (~r_d[ax] + 32'd1) : r_d[ax];
    assign c_q         = (r_quo > NUM_W'(ONE_FX)) ? NUM_W'(ONE_FX) : r_quo;
    assign c_dotv      = shr_trunc(r_dot);
    assign c_ay        = r_n[1][NORM_W-1] ? 32'(-r_n[1]) : 32'(r_n[1]);
    assign c_wall      = c_ay < 32'(i_wall_thr);

    always_ff @(posedge i_clk) begin
        r_prod <= c_mul_a * c_mul_b;
        case (i_cmd.op)
            DP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_pos[i] <= c_in_a[i];
                    r_vel[i] <= c_in_b[i];
                end
                r_rad      <= i_sphere_radius;
                r_hit      <= 1'b0;
                r_wall     <= 1'b0;
                r_floor    <= 1'b0;
                r_fbox     <= '0;
                r_fny      <= '0;
                r_pen_last <= '0;
            end
            DP_SET_RSQ: begin
                r_rsq <= r_prod[63:0];
            end
            DP_CLAMP: begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= c_clamp_d[i];
                end
            end
            DP_ACC_SQ: begin
                r_dsq <= (ax == AX_X) ? r_prod[63:0] : r_dsq + r_prod[63:0];
            end
            DP_SQRT_INIT: begin
                r_sq_x   <= r_dsq;
                r_sq_res <= '0;
                r_sq_bit <= 64'd1 << 62;
            end
            DP_SQRT_STEP: begin
                if ({1'b0, r_sq_x} >= c_sq_sum) begin
                    r_sq_x   <= r_sq_x - c_sq_sum[63:0];
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            DP_PEN: begin
                r_pen <= r_rad - r_sq_res[RAD_W-1:0];
                if (r_dsq == 64'd0) begin
                    r_n[0] <= '0;
                    r_n[1] <= ONE_FX;
                    r_n[2] <= '0;
                end
            end
            DP_DIV_INIT: begin
                r_num <= {c_d_mag, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_quo <= '0;
            end
            DP_DIV_STEP: begin
                // remainder stays below the divisor, so 32 bits hold it
                if (c_div_trial >= {1'b0, r_sq_res[31:0]}) begin
                    r_rem <= c_div_diff[31:0];
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= c_div_trial[31:0];
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                r_num <= r_num << 1;
            end
            DP_DIV_END: begin
                r_n[ax] <= r_d[ax][31] ? -$signed(c_q[NORM_W-1:0]) : $signed(c_q[NORM_W-1:0]);
            end
            DP_ACC_PUSH: begin
                r_pos[ax] <= sat32(34'(r_pos[ax]) + 34'(c_shr));
            end
            DP_ACC_DOT: begin
                r_dot <= (ax == AX_X) ? 68'(r_prod) : r_dot + 68'(r_prod);
            end
            DP_CLASSIFY: begin
                r_dotv     <= c_dotv;
                r_wall     <= c_wall;
                r_vadj     <= c_wall || c_dotv[31];
                r_hit      <= 1'b1;
                r_pen_last <= r_pen;
                if (!c_wall && !r_n[1][NORM_W-1] && (r_n[1] != '0)) begin
                    r_floor <= 1'b1;
                    r_fny   <= r_n[1];
                    r_fbox  <= i_box_idx;
                end
            end
            DP_ACC_VEL: begin
                r_vel[ax] <= sat32(34'(r_vel[ax]) - 34'(c_shr));
            end
            default: begin
            end
        endcase
    end

    // ---- result register -------------------------------------------------------
    logic [31:0] c_fbox32, c_fny32;

    assign c_fbox32 = 32'(r_fbox);
    assign c_fny32  = 32'(unsigned'(r_fny));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == DP_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == DP_OUT_LOAD) begin
            o_hit              <= r_hit;
            o_last_was_wall    <= r_wall;
            o_floor_contact    <= r_floor;
            o_floor_box        <= c_fbox32[5:0];
            o_out_pos_x        <= r_pos[0];
            o_out_pos_y        <= r_pos[1];
            o_out_pos_z        <= r_pos[2];
            o_out_vel_x        <= r_vel[0];
            o_out_vel_y        <= r_vel[1];
            o_out_vel_z        <= r_vel[2];
            o_last_penetration <= r_pen_last;
            o_floor_normal_y   <= c_fny32[16:0];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status.dsq_lt_rsq = r_dsq < r_rsq;
    assign o_status.dsq_zero   = r_dsq == 64'd0;
    assign o_status.vel_adj    = r_vadj;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

// ===== hw/rtl/sphere_box_collision_resolver.sv =====
// ----------------------------------------------------------------------------
// sphere_box_collision_resolver
// Sphere against box-table collision resolver with wall sliding, Q16.16.
// ----------------------------------------------------------------------------
// Box write word: taken while idle, input ready again the next cycle.
// Resolve word: input stalls until the result is loaded; each pass walks the
//   box table, and each hit runs a 32-step square root and three bit-serial
//   divisions skipped at zero distance, with one shared multiplier.
// Reset clears the controller, config registers and output valid; the box
//   table is not cleared and must be written before it is used.
// ----------------------------------------------------------------------------
module sphere_box_collision_resolver import sbcr_pkg::*; #(
    parameter int MAX_BOXES = DEF_MAX_BOXES,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_op,
    input  logic [5:0]              i_box_slot,
    input  logic signed [VAL_W-1:0] i_value_a_x,
    input  logic signed [VAL_W-1:0] i_value_a_y,
    input  logic signed [VAL_W-1:0] i_value_a_z,
    input  logic signed [VAL_W-1:0] i_value_b_x,
    input  logic signed [VAL_W-1:0] i_value_b_y,
    input  logic signed [VAL_W-1:0] i_value_b_z,
    input  logic [RAD_W-1:0]        i_sphere_radius,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [16:0]             i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_hit,
    output logic                    o_last_was_wall,
    output logic                    o_floor_contact,
    output logic [5:0]              o_floor_box,
    output logic signed [VAL_W-1:0] o_out_pos_x,
    output logic signed [VAL_W-1:0] o_out_pos_y,
    output logic signed [VAL_W-1:0] o_out_pos_z,
    output logic signed [VAL_W-1:0] o_out_vel_x,
    output logic signed [VAL_W-1:0] o_out_vel_y,
    output logic signed [VAL_W-1:0] o_out_vel_z,
    output logic [RAD_W-1:0]        o_last_penetration,
    output logic [16:0]             o_floor_normal_y
);

    localparam int CW = $clog2(MAX_BOXES + 1);

    logic [6:0]    r_box_count;
    logic [16:0]   r_wall_thr;
    logic [3:0]    r_max_passes;
    t_dp_cmd       c_cmd;
    t_dp_status    c_status;
    logic [CW-1:0] c_box_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count  <= RST_BOX_COUNT;
            r_wall_thr   <= RST_WALL_THR;
            r_max_passes <= RST_MAX_PASSES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOX_COUNT:  r_box_count  <= i_cfg_data[6:0];
                CFG_WALL_THR:   r_wall_thr   <= i_cfg_data;
                CFG_MAX_PASSES: r_max_passes <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    sbcr_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_op         (i_op),
        .o_in_stall   (o_in_stall),
        .i_box_count  (r_box_count),
        .i_max_passes (r_max_passes),
        .i_status     (c_status),
        .o_cmd        (c_cmd),
        .o_box_idx    (c_box_idx)
    );

    sbcr_dp #(
        .MAX_BOXES (MAX_BOXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (c_cmd),
        .i_box_idx          (c_box_idx),
        .i_box_slot         (i_box_slot),
        .i_value_a_x        (i_value_a_x),
        .i_value_a_y        (i_value_a_y),
        .i_value_a_z        (i_value_a_z),
        .i_value_b_x        (i_value_b_x),
        .i_value_b_y        (i_value_b_y),
        .i_value_b_z        (i_value_b_z),
        .i_sphere_radius    (i_sphere_radius),
        .i_wall_thr         (r_wall_thr),
        .i_out_stall        (i_out_stall),
        .o_status           (c_status),
        .o_out_valid        (o_out_valid),
        .o_hit              (o_hit),
        .o_last_was_wall    (o_last_was_wall),
        .o_floor_contact    (o_floor_contact),
        .o_floor_box        (o_floor_box),
        .o_out_pos_x        (o_out_pos_x),
        .o_out_pos_y        (o_out_pos_y),
        .o_out_pos_z        (o_out_pos_z),
        .o_out_vel_x        (o_out_vel_x),
        .o_out_vel_y        (o_out_vel_y),
        .o_out_vel_z        (o_out_vel_z),
        .o_last_penetration (o_last_penetration),
        .o_floor_normal_y   (o_floor_normal_y)
    );

endmodule

// ===== tb/sbcr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbcr_checker
// Watches the config, box/resolve and result channels of the collision
// resolver, keeps a shadow box table, predicts each resolve word and compares.
// ----------------------------------------------------------------------------
module sbcr_checker import sbcr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    o_in_stall,
    input  logic                    i_op,
    input  logic [5:0]              i_box_slot,
    input  logic signed [VAL_W-1:0] i_value_a_x,
    input  logic signed [VAL_W-1:0] i_value_a_y,
    input  logic signed [VAL_W-1:0] i_value_a_z,
    input  logic signed [VAL_W-1:0] i_value_b_x,
    input  logic signed [VAL_W-1:0] i_value_b_y,
    input  logic signed [VAL_W-1:0] i_value_b_z,
    input  logic [RAD_W-1:0]        i_sphere_radius,
    input  logic                    i_cfg_valid,
    input  logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [16:0]             i_cfg_data,
    input  logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  logic                    o_hit,
    input  logic                    o_last_was_wall,
    input  logic                    o_floor_contact,
    input  logic [5:0]              o_floor_box,
    input  logic signed [VAL_W-1:0] o_out_pos_x,
    input  logic signed [VAL_W-1:0] o_out_pos_y,
    input  logic signed [VAL_W-1:0] o_out_pos_z,
    input  logic signed [VAL_W-1:0] o_out_vel_x,
    input  logic signed [VAL_W-1:0] o_out_vel_y,
    input  logic signed [VAL_W-1:0] o_out_vel_z,
    input  logic [RAD_W-1:0]        o_last_penetration,
    input  logic [16:0]             o_floor_normal_y,
    output int                      err_count,
    output int                      pending_count,
    output int                      hit_count,
    output int                      floor_count
);

    localparam longint ONE = 64'sd1 <<< DEF_FRAC_BITS;

    typedef struct packed {
        logic                    hit;
        logic                    wall;
        logic                    flr;
        logic [5:0]              fbox;
        logic signed [VAL_W-1:0] px, py, pz;
        logic signed [VAL_W-1:0] vx, vy, vz;
        logic [RAD_W-1:0]        pen;
        logic [16:0]             fny;
    } t_contact;

    longint      box_ctr [DEF_MAX_BOXES][3];
    longint      box_half[DEF_MAX_BOXES][3];
    logic [6:0]  box_count;
    logic [16:0] wall_thr;
    logic [3:0]  max_passes;
    t_contact    contact_q[$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // drop fraction bits, truncating toward zero
    function automatic longint trunc_q(longint p);
        longint m;
        m = p < 0 ? -p : p;
        m = m >>> DEF_FRAC_BITS;
        if (m > (64'sd1 <<< 40)) m = 64'sd1 <<< 40;
        return sat32(p < 0 ? -m : m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bv;
        res = 0;
        bv = 64'd1 << 62;
        while (bv > x) bv = bv >> 2;
        while (bv != 0) begin
            if (x >= res + bv) begin
                x = x - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    function automatic t_contact resolve_sphere(longint ax, longint ay, longint az,
                                                longint bx, longint by, longint bz,
                                                longint unsigned r);
        t_contact res;
        longint pos[3], vel[3], d[3], n[3];
        longint lo, hi, c, dotv, aby;
        longint unsigned rsq, dsq, mag, pen, m, q, pen_last;
        int cnt, p, b, i;
        logic any, hit, wall, flr;
        int fbox;
        longint fny;
        pos[0] = ax; pos[1] = ay; pos[2] = az;
        vel[0] = bx; vel[1] = by; vel[2] = bz;
        rsq = r * r;
        cnt = box_count > DEF_MAX_BOXES ? DEF_MAX_BOXES : box_count;
        hit = 0; wall = 0; flr = 0; fbox = 0; fny = 0; pen_last = 0;
        for (p = 0; p < max_passes; p++) begin
            any = 0;
            for (b = 0; b < cnt; b++) begin
                dsq = 0;
                for (i = 0; i < 3; i++) begin
                    lo = sat32(box_ctr[b][i] - box_half[b][i]);
                    hi = sat32(box_ctr[b][i] + box_half[b][i]);
                    c = pos[i] < hi ? pos[i] : hi;
                    if (lo > c) c = lo;
                    d[i] = sat32(pos[i] - c);
                    dsq += longint'(d[i] * d[i]);
                end
                if (!(dsq < rsq)) continue;
                mag = int_sqrt(dsq);
                pen = r - mag;
                if (dsq == 0) begin
                    n[0] = 0; n[1] = ONE; n[2] = 0;
                end else begin
                    for (i = 0; i < 3; i++) begin
                        m = d[i] < 0 ? -d[i] : d[i];
                        q = (m << DEF_FRAC_BITS) / mag;
                        if (q > ONE) q = ONE;
                        n[i] = d[i] < 0 ? -longint'(q) : longint'(q);
                    end
                end
                for (i = 0; i < 3; i++)
                    pos[i] = sat32(pos[i] + trunc_q(n[i] * longint'(pen)));
                dotv = trunc_q(vel[0] * n[0] + vel[1] * n[1] + vel[2] * n[2]);
                aby = n[1] < 0 ? -n[1] : n[1];
                wall = aby < longint'(wall_thr);
                // walls slide; floors and ceilings only lose inward speed
                if (wall || dotv < 0)
                    for (i = 0; i < 3; i++)
                        vel[i] = sat32(vel[i] - trunc_q(n[i] * dotv));
                if (!wall && n[1] > 0) begin
                    flr = 1; fny = n[1]; fbox = b;
                end
                hit = 1;
                pen_last = pen;
                any = 1;
            end
            if (!any) break;
        end
        res.hit = hit;
        res.wall = wall && hit;
        res.flr = flr;
        res.fbox = fbox[5:0];
        res.px = pos[0][31:0]; res.py = pos[1][31:0]; res.pz = pos[2][31:0];
        res.vx = vel[0][31:0]; res.vy = vel[1][31:0]; res.vz = vel[2][31:0];
        res.pen = pen_last[30:0];
        res.fny = fny[16:0];
        return res;
    endfunction

    task automatic report(string msg);
        $display("%0t checker: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    t_contact exp_c;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_count  <= RST_BOX_COUNT;
            wall_thr   <= RST_WALL_THR;
            max_passes <= RST_MAX_PASSES;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BOX_COUNT:  box_count  <= i_cfg_data[6:0];
                    CFG_WALL_THR:   wall_thr   <= i_cfg_data;
                    CFG_MAX_PASSES: max_passes <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (contact_q.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    exp_c = contact_q.pop_front();
                    check_field("hit", o_hit, exp_c.hit);
                    check_field("last_was_wall", o_last_was_wall, exp_c.wall);
                    check_field("floor_contact", o_floor_contact, exp_c.flr);
                    check_field("floor_box", o_floor_box, exp_c.fbox);
                    check_field("pos_x", o_out_pos_x, exp_c.px);
                    check_field("pos_y", o_out_pos_y, exp_c.py);
                    check_field("pos_z", o_out_pos_z, exp_c.pz);
                    check_field("vel_x", o_out_vel_x, exp_c.vx);
                    check_field("vel_y", o_out_vel_y, exp_c.vy);
                    check_field("vel_z", o_out_vel_z, exp_c.vz);
                    check_field("penetration", o_last_penetration, exp_c.pen);
                    check_field("floor_normal_y", o_floor_normal_y, exp_c.fny);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (i_op == OP_WRITE) begin
                    box_ctr[i_box_slot][0]  = longint'(i_value_a_x);
                    box_ctr[i_box_slot][1]  = longint'(i_value_a_y);
                    box_ctr[i_box_slot][2]  = longint'(i_value_a_z);
                    box_half[i_box_slot][0] = longint'(i_value_b_x);
                    box_half[i_box_slot][1] = longint'(i_value_b_y);
                    box_half[i_box_slot][2] = longint'(i_value_b_z);
                end else begin
                    exp_c = resolve_sphere(i_value_a_x, i_value_a_y, i_value_a_z,
                                           i_value_b_x, i_value_b_y, i_value_b_z,
                                           i_sphere_radius);
                    if (exp_c.hit) hit_count++;
                    if (exp_c.flr) floor_count++;
                    contact_q.push_back(exp_c);
                end
            end
            pending_count <= contact_q.size();
        end
    end

    initial begin
        err_count = 0;
        pending_count = 0;
        hit_count = 0;
        floor_count = 0;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives box writes, resolve words and config writes into the collision
// resolver with random gaps and output stalls; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
    import sbcr_pkg::*;

    localparam int Q = 65536;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_op;
    logic [5:0]              i_box_slot;
    logic signed [VAL_W-1:0] i_value_a_x, i_value_a_y, i_value_a_z;
    logic signed [VAL_W-1:0] i_value_b_x, i_value_b_y, i_value_b_z;
    logic [RAD_W-1:0]        i_sphere_radius;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index;
    logic [16:0]             i_cfg_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_hit, o_last_was_wall, o_floor_contact;
    logic [5:0]              o_floor_box;
    logic signed [VAL_W-1:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [VAL_W-1:0] o_out_vel_x, o_out_vel_y, o_out_vel_z;
    logic [RAD_W-1:0]        o_last_penetration;
    logic [16:0]             o_floor_normal_y;
    int                      err_count, pending_count, hit_count, floor_count;

    logic in_took, cfg_took, quiet;
    int   resolves_sent, guard;

    sphere_box_collision_resolver uut (.*);
    sbcr_checker chk (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        in_took  <= i_in_valid && !o_in_stall;
        cfg_took <= i_cfg_valid && o_cfg_ready;
    end

    always @(negedge i_clk)
        i_out_stall = quiet ? 1'b0 : ($urandom_range(99) < 11);

    function automatic logic signed [31:0] spread(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_word(logic op, logic [5:0] slot,
                             logic signed [31:0] ax, ay, az, bx, by, bz,
                             logic [30:0] r);
        if (!quiet && $urandom_range(99) < 11) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_op = op; i_box_slot = slot;
        i_value_a_x = ax; i_value_a_y = ay; i_value_a_z = az;
        i_value_b_x = bx; i_value_b_y = by; i_value_b_z = bz;
        i_sphere_radius = r;
        i_in_valid = 1'b1;
        do @(negedge i_clk); while (!in_took);
        if (op == OP_RESOLVE) resolves_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        // a trailing box write may still be in flight
        repeat (20) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [16:0] data);
        i_cfg_index = idx; i_cfg_data = data; i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (!cfg_took);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(int cnt, int thr, int passes);
        wait_idle();
        cfg_write(CFG_BOX_COUNT, 17'(cnt));
        cfg_write(CFG_WALL_THR, 17'(thr));
        cfg_write(CFG_MAX_PASSES, 17'(passes));
    endtask

    task automatic random_box(logic [5:0] slot);
        if ($urandom_range(9) == 0)
            send_word(OP_WRITE, slot, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, 31'($urandom));
        else
            send_word(OP_WRITE, slot, spread(8 * Q), spread(8 * Q), spread(8 * Q),
                      $urandom_range(Q / 4, 2 * Q), $urandom_range(Q / 4, 2 * Q),
                      $urandom_range(Q / 4, 2 * Q), 31'($urandom));
    endtask

    task automatic random_sphere();
        if ($urandom_range(9) == 0)
            send_word(OP_RESOLVE, 6'($urandom), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, 31'($urandom));
        else
            send_word(OP_RESOLVE, 6'($urandom), spread(10 * Q), spread(10 * Q),
                      spread(10 * Q), spread(4 * Q), spread(4 * Q), spread(4 * Q),
                      31'($urandom_range(Q / 2, 3 * Q)));
    endtask

    task automatic random_phase(int cnt, int thr, int passes, int n_items);
        set_config(cnt, thr, passes);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(3) == 0) random_box(6'($urandom_range(63)));
            else random_sphere();
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_cfg_valid = 1'b0; i_out_stall = 1'b0;
        i_op = OP_WRITE; i_box_slot = '0; i_cfg_index = CFG_BOX_COUNT; i_cfg_data = '0;
        i_value_a_x = '0; i_value_a_y = '0; i_value_a_z = '0;
        i_value_b_x = '0; i_value_b_y = '0; i_value_b_z = '0;
        i_sphere_radius = '0;
        quiet = 1'b0; resolves_sent = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset box count is zero: resolve echoes its inputs
        send_word(OP_RESOLVE, 6'd0, 32'sh7fffffff, 32'sh80000000, 0,
                  32'sh80000000, 32'sh7fffffff, -1, 31'h7fffffff);

        // fill the whole table so no entry is read before it is written
        for (int s = 4; s < 64; s++) random_box(6'(s));
        send_word(OP_WRITE, 0, 0, 0, 0, Q, Q, Q, 0);
        send_word(OP_WRITE, 1, 3 * Q, 0, 0, Q / 2, 2 * Q, 2 * Q, 0);
        send_word(OP_WRITE, 2, 0, -3 * Q, 0, 4 * Q, Q, 4 * Q, 0);
        send_word(OP_WRITE, 3, 6 * Q, 6 * Q, 6 * Q, -Q, -Q, -Q, 0);

        set_config(4, RST_WALL_THR, RST_MAX_PASSES);
        send_word(OP_RESOLVE, 0, 0, 0, 0, Q, -Q, Q, 31'(Q / 2));             // centre inside
        send_word(OP_RESOLVE, 0, 22 * Q / 10, 0, 0, Q, 0, Q / 3, 31'(Q / 2)); // wall slide
        send_word(OP_RESOLVE, 0, 0, -17 * Q / 10, 0, Q, -Q, 0, 31'(Q / 2));   // floor
        send_word(OP_RESOLVE, 0, 0, 13 * Q / 10, 0, 0, 2 * Q, 0, 31'(Q / 2)); // moving away
        send_word(OP_RESOLVE, 0, 6 * Q, 6 * Q, 6 * Q, 0, 0, 0, 31'(Q));      // inverted box
        send_word(OP_RESOLVE, 0, 0, 0, 0, 0, 0, 0, 0);                       // zero radius
        send_word(OP_RESOLVE, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff);
        send_word(OP_RESOLVE, 0, 32'sh80000000, 0, 32'sh7fffffff,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff);
        send_word(OP_WRITE, 63, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0);

        fork
            begin
                repeat (20) @(negedge i_clk);
                quiet = 1'b1;
                repeat (3000) @(negedge i_clk);
                quiet = 1'b0;
            end
            random_phase(4, RST_WALL_THR, 3, 60);
        join
        quiet = 1'b0;
        random_phase(8, 0, 1, 40);
        random_phase(8, 65536, 8, 40);
        random_phase(6, 131071, 2, 30);
        random_phase(5, $urandom_range(65536), 0, 20);
        random_phase(64, RST_WALL_THR, 3, 15);
        random_phase(127, 20000, 15, 8);
        random_phase(3, RST_WALL_THR, 4, 25);
        wait_idle();      // sender holds until every result is back
        random_phase(3, $urandom_range(30000, 60000), $urandom_range(1, 4), 25);

        i_in_valid = 1'b0;
        guard = 0;
        while (pending_count != 0 && guard < 5000000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (50) @(negedge i_clk);
        $display("resolves %0d, with contact %0d, with floor contact %0d",
                 resolves_sent, hit_count, floor_count);
        $display("box counts 0..127, wall bounds 0..131071, passes 0..15 exercised");
        if (err_count == 0 && pending_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #500ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
